FILE: hw/rtl/bgc_pkg.sv
// Package for the button gesture classifier: payload structs, configuration
// struct, register indexes and reset values. No dependencies.
package bgc_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLL_INTERVAL  = 2'd0,
        CFG_LONG_THRESHOLD = 2'd1,
        CFG_MIN_TAP        = 2'd2
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_POLL_MS = 16'd20;
    localparam logic [CFG_W-1:0] RST_LONG_MS = 16'd1500;
    localparam logic [CFG_W-1:0] RST_TAP_MS  = 16'd50;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              pin_level;
        logic              ack_short;
        logic              ack_long;
        logic              ack_released;
    } t_in_item;

    typedef struct packed {
        logic short_tap;
        logic long_press;
        logic long_release;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] poll_interval_ms;
        logic [CFG_W-1:0] long_threshold_ms;
        logic [CFG_W-1:0] min_tap_ms;
    } t_cfg;

endpackage

FILE: hw/rtl/bgc_cfg.sv
// Configuration register file of the button gesture classifier.
// Depends on bgc_pkg for the register indexes, reset values and t_cfg.
module bgc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bgc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bgc_pkg::CFG_W-1:0]     i_cfg_data,
    output bgc_pkg::t_cfg                 o_cfg
);

    bgc_pkg::t_cfg r_cfg;
    bgc_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                bgc_pkg::CFG_POLL_INTERVAL:  n_cfg.poll_interval_ms  = i_cfg_data;
                bgc_pkg::CFG_LONG_THRESHOLD: n_cfg.long_threshold_ms = i_cfg_data;
                bgc_pkg::CFG_MIN_TAP:        n_cfg.min_tap_ms        = i_cfg_data;
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_interval_ms  <= bgc_pkg::RST_POLL_MS;
            r_cfg.long_threshold_ms <= bgc_pkg::RST_LONG_MS;
            r_cfg.min_tap_ms        <= bgc_pkg::RST_TAP_MS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: hw/rtl/bgc_core.sv
// Classifier state and the single-pass update logic for one sample.
// Depends on bgc_pkg for t_in_item, t_out_item and t_cfg.
module bgc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  bgc_pkg::t_in_item  i_item,
    input  bgc_pkg::t_cfg      i_cfg,
    output bgc_pkg::t_out_item o_result
);

    logic [bgc_pkg::TIME_W-1:0] r_last_sample;
    logic [bgc_pkg::TIME_W-1:0] r_press_start;
    logic                       r_was_pressed;
    logic                       r_long_reported;
    logic                       r_short_pend;
    logic                       r_long_pend;
    logic                       r_release_pend;

    logic [bgc_pkg::TIME_W-1:0] n_last_sample;
    logic [bgc_pkg::TIME_W-1:0] n_press_start;
    logic                       n_was_pressed;
    logic                       n_long_reported;
    logic                       n_short_pend;
    logic                       n_long_pend;
    logic                       n_release_pend;

    logic [bgc_pkg::TIME_W-1:0] since_sample;
    logic [bgc_pkg::TIME_W-1:0] held;
    logic                       sample_used;
    logic                       pressed;
    logic                       flag_short;
    logic                       flag_long;
    logic                       flag_release;

    assign pressed      = ~i_item.pin_level;
    assign since_sample = i_item.now_ms - r_last_sample;
    assign held         = i_item.now_ms - r_press_start;
    assign sample_used  = since_sample >=
        {{(bgc_pkg::TIME_W-bgc_pkg::CFG_W){1'b0}}, i_cfg.poll_interval_ms};

    always_comb begin
        n_last_sample   = r_last_sample;
        n_press_start   = r_press_start;
        n_was_pressed   = r_was_pressed;
        n_long_reported = r_long_reported;
        flag_short      = r_short_pend;
        flag_long       = r_long_pend;
        flag_release    = r_release_pend;
        if (sample_used) begin
            n_last_sample = i_item.now_ms;
            n_was_pressed = pressed;
            if (pressed && !r_was_pressed) begin
                n_press_start   = i_item.now_ms;
                n_long_reported = 1'b0;
            end else if (pressed && !r_long_reported && held >=
                         {{(bgc_pkg::TIME_W-bgc_pkg::CFG_W){1'b0}},
                          i_cfg.long_threshold_ms}) begin
                flag_long       = 1'b1;
                n_long_reported = 1'b1;
            end else if (!pressed && r_was_pressed) begin
                // A hold that already raised the long flag ends as a long release.
                if (r_long_reported) begin
                    flag_release = 1'b1;
                end else if (held >= {{(bgc_pkg::TIME_W-bgc_pkg::CFG_W){1'b0}},
                                      i_cfg.min_tap_ms}) begin
                    flag_short = 1'b1;
                end
            end
        end
        n_short_pend   = flag_short   & ~i_item.ack_short;
        n_long_pend    = flag_long    & ~i_item.ack_long;
        n_release_pend = flag_release & ~i_item.ack_released;
    end

    assign o_result.short_tap    = flag_short;
    assign o_result.long_press   = flag_long;
    assign o_result.long_release = flag_release;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sample   <= '0;
            r_press_start   <= '0;
            r_was_pressed   <= 1'b0;
            r_long_reported <= 1'b0;
            r_short_pend    <= 1'b0;
            r_long_pend     <= 1'b0;
            r_release_pend  <= 1'b0;
        end else if (i_fire) begin
            r_last_sample   <= n_last_sample;
            r_press_start   <= n_press_start;
            r_was_pressed   <= n_was_pressed;
            r_long_reported <= n_long_reported;
            r_short_pend    <= n_short_pend;
            r_long_pend     <= n_long_pend;
            r_release_pend  <= n_release_pend;
        end
    end

endmodule

FILE: hw/rtl/button_gesture_classifier.sv
// Top level of the button gesture classifier: input register, classifier
// core, result register and configuration registers. Depends on bgc_pkg,
// bgc_cfg and bgc_core.
//
// Classifies one active-low button into short taps, long presses and
// releases after a long press, from timestamped pin samples. Each accepted
// transaction yields exactly one result transaction holding the three sticky
// flags after that sample; its acknowledge bits clear the flags afterwards.
// The block takes one transaction per clock cycle while the result register
// is free or drains; back-pressure on the output stalls it. An accepted
// transaction is held in the input register, and the classifier output is
// captured in the result register when the held item moves on. The
// classifier state update sits between those two registers. Configuration
// writes take effect in the following cycle and are to be made while no
// transaction is in flight.
module button_gesture_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bgc_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bgc_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bgc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bgc_pkg::CFG_W-1:0]     i_cfg_data
);

    bgc_pkg::t_cfg      cfg;
    bgc_pkg::t_in_item  r_in_data;
    logic               r_in_valid;
    bgc_pkg::t_out_item r_out_data;
    logic               r_out_valid;
    bgc_pkg::t_out_item result;
    logic               advance;

    // The held item moves on whenever the result register is free or drains.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    bgc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bgc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

`ifndef SYNTHESIS
    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed transaction did not reach the result register");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input not ready while the result register is empty");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("stalled input transaction was dropped");
`endif

endmodule

FILE: tb/sv/button_gesture_classifier_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for button_gesture_classifier: directed gestures, then
// random press sequences under several register settings. Depends on bgc_pkg.
module button_gesture_classifier_test;

    localparam logic [bgc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam bit PIN_PRESSED  = 1'b0;
    localparam bit PIN_RELEASED = 1'b1;
    // Acknowledge bit order: {short, long, released}.
    localparam bit [2:0] ACK_NONE     = 3'b000;
    localparam bit [2:0] ACK_SHORT    = 3'b100;
    localparam bit [2:0] ACK_LONG     = 3'b010;
    localparam bit [2:0] ACK_RELEASED = 3'b001;
    localparam bit [2:0] ACK_ALL      = 3'b111;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASE_ITEMS   = 170;
    localparam int REPORT_LIMIT  = 100;

    class gesture_scoreboard;
        bgc_pkg::t_cfg      cfg;
        logic [31:0]        last_sample_ms;
        logic [31:0]        press_start_ms;
        bit                 was_pressed;
        bit                 long_seen;
        bit                 short_pend;
        bit                 long_pend;
        bit                 release_flag;
        bgc_pkg::t_out_item expected_flags[$];
        int                 errors;

        function new();
            cfg.poll_interval_ms  = bgc_pkg::RST_POLL_MS;
            cfg.long_threshold_ms = bgc_pkg::RST_LONG_MS;
            cfg.min_tap_ms        = bgc_pkg::RST_TAP_MS;
            last_sample_ms = '0;
            press_start_ms = '0;
            was_pressed    = 1'b0;
            long_seen      = 1'b0;
            short_pend     = 1'b0;
            long_pend      = 1'b0;
            release_flag   = 1'b0;
            errors         = 0;
        endfunction

        function void write_reg(logic [bgc_pkg::CFG_IDX_W-1:0] idx,
                                logic [bgc_pkg::CFG_W-1:0] value);
            case (idx)
                bgc_pkg::CFG_POLL_INTERVAL:  cfg.poll_interval_ms  = value;
                bgc_pkg::CFG_LONG_THRESHOLD: cfg.long_threshold_ms = value;
                bgc_pkg::CFG_MIN_TAP:        cfg.min_tap_ms        = value;
                default: ;
            endcase
        endfunction

        function void note_input(bgc_pkg::t_in_item item);
            logic [31:0]        since;
            logic [31:0]        held;
            bit                 pressed;
            bgc_pkg::t_out_item flags;
            since   = item.now_ms - last_sample_ms;
            held    = item.now_ms - press_start_ms;
            pressed = (item.pin_level == PIN_PRESSED);
            if (since >= {16'd0, cfg.poll_interval_ms}) begin
                last_sample_ms = item.now_ms;
                if (pressed && !was_pressed) begin
                    press_start_ms = item.now_ms;
                    long_seen      = 1'b0;
                end else if (pressed && !long_seen &&
                             held >= {16'd0, cfg.long_threshold_ms}) begin
                    long_pend = 1'b1;
                    long_seen = 1'b1;
                end else if (!pressed && was_pressed) begin
                    if (long_seen)
                        release_flag = 1'b1;
                    else if (held >= {16'd0, cfg.min_tap_ms})
                        short_pend = 1'b1;
                end
                was_pressed = pressed;
            end
            flags.short_tap    = short_pend;
            flags.long_press   = long_pend;
            flags.long_release = release_flag;
            expected_flags.push_back(flags);
            // The acknowledges clear the flags only after the result is formed.
            if (item.ack_short)    short_pend   = 1'b0;
            if (item.ack_long)     long_pend    = 1'b0;
            if (item.ack_released) release_flag = 1'b0;
        endfunction

        task report(string msg);
            if (errors < REPORT_LIMIT)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(bgc_pkg::t_out_item got);
            bgc_pkg::t_out_item want;
            if (expected_flags.size() == 0) begin
                report("result transaction with nothing pending");
            end else begin
                want = expected_flags.pop_front();
                if (got.short_tap !== want.short_tap)
                    report($sformatf("short_tap got %b want %b", got.short_tap,
                                     want.short_tap));
                if (got.long_press !== want.long_press)
                    report($sformatf("long_press got %b want %b", got.long_press,
                                     want.long_press));
                if (got.long_release !== want.long_release)
                    report($sformatf("long_release got %b want %b", got.long_release,
                                     want.long_release));
            end
        endtask

        function int pending();
            return expected_flags.size();
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    bgc_pkg::t_in_item             i_in_data;
    logic                          o_out_valid;
    logic                          i_out_ready;
    bgc_pkg::t_out_item            o_out_data;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [bgc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [bgc_pkg::CFG_W-1:0]     i_cfg_data;

    gesture_scoreboard         sb;
    bit                        tx_idling;
    bit                        rx_idling;
    bit                        hold_toggle;
    int                        items_sent;
    logic [31:0]               cursor_ms;
    logic [bgc_pkg::CFG_W-1:0] cur_poll;
    logic [bgc_pkg::CFG_W-1:0] cur_long;
    logic [bgc_pkg::CFG_W-1:0] cur_tap;

    button_gesture_classifier u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Everything is driven at rising edges, so the falling edge sees settled
    // handshakes for the edge that follows.
    always @(negedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out_data);
            if (i_in_valid && o_in_ready)
                sb.note_input(i_in_data);
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    initial begin : receiver
        bit hold_seen;
        int hold_cnt;
        hold_seen   = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                i_out_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge i_clk);
            end
            i_out_ready <= !rx_idling || ($urandom_range(99) >= 35);
        end
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit [2:0] rand_acks();
        bit [2:0] acks;
        acks[2] = ($urandom_range(99) < 30);
        acks[1] = ($urandom_range(99) < 30);
        acks[0] = ($urandom_range(99) < 30);
        return acks;
    endfunction

    task automatic send_sample(input logic [31:0] now, input bit pin, input bit [2:0] acks);
        bgc_pkg::t_in_item item;
        item.now_ms       = now;
        item.pin_level    = pin;
        item.ack_short    = acks[2];
        item.ack_long     = acks[1];
        item.ack_released = acks[0];
        while (tx_idling && $urandom_range(99) < 35) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(negedge i_clk);
        while (!o_in_ready)
            @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [bgc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bgc_pkg::CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        while (!o_cfg_ready)
            @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [bgc_pkg::CFG_W-1:0] poll,
                             input logic [bgc_pkg::CFG_W-1:0] long_ms,
                             input logic [bgc_pkg::CFG_W-1:0] tap);
        wait_drained();
        write_cfg(bgc_pkg::CFG_POLL_INTERVAL, poll);
        write_cfg(bgc_pkg::CFG_LONG_THRESHOLD, long_ms);
        write_cfg(bgc_pkg::CFG_MIN_TAP, tap);
        cur_poll = poll;
        cur_long = long_ms;
        cur_tap  = tap;
    endtask

    // Mostly complete press/hold/release gestures with a hold aimed at noise,
    // short-tap or long-press length, mixed with samples at arbitrary times.
    task automatic run_gestures(input int count);
        int unsigned goal;
        int unsigned hold;
        int unsigned unit;
        int unsigned kind;
        logic [31:0] start_ms;
        goal = items_sent + count;
        while (items_sent < goal) begin
            kind = $urandom_range(0, 9);
            if (kind >= 8) begin
                repeat ($urandom_range(1, 4))
                    send_sample($urandom, 1'($urandom_range(0, 1)), rand_acks());
            end else begin
                case (kind % 3)
                    0:       hold = $urandom_range(0, 32'(cur_tap));
                    1:       hold = $urandom_range(32'(cur_tap), 32'(cur_long));
                    default: hold = $urandom_range(32'(cur_long),
                                                   32'(cur_long) + 32'(cur_long) / 2 +
                                                   32'(cur_poll) + 8);
                endcase
                unit = (32'(cur_poll) > hold / 4) ? 32'(cur_poll) : hold / 4;
                if (unit == 0)
                    unit = 1;
                repeat ($urandom_range(0, 2)) begin
                    cursor_ms = cursor_ms + $urandom_range(unit / 2, unit + unit / 2);
                    send_sample(cursor_ms, PIN_RELEASED, rand_acks());
                end
                cursor_ms = cursor_ms + 32'(cur_poll) + $urandom_range(0, unit / 2);
                start_ms  = cursor_ms;
                send_sample(cursor_ms, PIN_PRESSED, rand_acks());
                forever begin
                    cursor_ms = cursor_ms + $urandom_range(unit / 2, unit + unit / 2);
                    if (cursor_ms - start_ms >= hold)
                        break;
                    send_sample(cursor_ms, PIN_PRESSED, rand_acks());
                end
                cursor_ms = start_ms + hold + $urandom_range(0, 1);
                send_sample(cursor_ms, PIN_RELEASED, rand_acks());
            end
        end
    endtask

    initial begin
        int phase;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        tx_idling   = 1'b1;
        rx_idling   = 1'b1;
        hold_toggle = 1'b0;
        items_sent  = 0;
        cursor_ms   = 32'h0000_1000;
        cur_poll    = bgc_pkg::RST_POLL_MS;
        cur_long    = bgc_pkg::RST_LONG_MS;
        cur_tap     = bgc_pkg::RST_TAP_MS;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: skipped samples, a noise press, a tap, a long hold.
        send_sample(32'd0,    PIN_RELEASED, ACK_NONE);
        send_sample(32'd25,   PIN_PRESSED,  ACK_NONE);
        send_sample(32'd30,   PIN_RELEASED, ACK_NONE);
        send_sample(32'd60,   PIN_RELEASED, ACK_NONE);
        send_sample(32'd100,  PIN_PRESSED,  ACK_NONE);
        send_sample(32'd200,  PIN_RELEASED, ACK_NONE);
        send_sample(32'd210,  PIN_RELEASED, ACK_SHORT);
        send_sample(32'd300,  PIN_PRESSED,  ACK_NONE);
        send_sample(32'd1900, PIN_PRESSED,  ACK_NONE);
        send_sample(32'd2000, PIN_PRESSED,  ACK_LONG);
        send_sample(32'd2100, PIN_RELEASED, ACK_NONE);
        send_sample(32'd2200, PIN_RELEASED, ACK_RELEASED);
        // A tap that straddles the timestamp wrap.
        send_sample(32'hFFFF_FFF0, PIN_PRESSED,  ACK_NONE);
        send_sample(32'h0000_0040, PIN_RELEASED, ACK_NONE);
        send_sample(32'h0000_0060, PIN_RELEASED, ACK_ALL);
        // With a zero threshold the long flag still waits for the next sample.
        configure(16'd0, 16'd0, 16'd0);
        send_sample(32'h0000_0060, PIN_PRESSED,  ACK_NONE);
        send_sample(32'h0000_0060, PIN_PRESSED,  ACK_NONE);
        send_sample(32'h0000_0060, PIN_RELEASED, ACK_NONE);
        send_sample(32'h0000_0060, PIN_RELEASED, ACK_ALL);
        send_sample(32'h0000_0061, PIN_RELEASED, ACK_NONE);
        send_sample(32'h0000_0062, PIN_PRESSED,  ACK_ALL);
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(32'hFFFF_FFFF, PIN_RELEASED, ACK_NONE);
        send_sample(32'h0001_0000, PIN_PRESSED,  ACK_NONE);
        send_sample(32'h0002_0000, PIN_RELEASED, ACK_ALL);

        for (phase = 0; phase < 8; phase++) begin
            tx_idling = !(phase == 3 || phase == 4);
            rx_idling = (phase != 3);
            case (phase)
                0:       configure(bgc_pkg::RST_POLL_MS, bgc_pkg::RST_LONG_MS,
                                   bgc_pkg::RST_TAP_MS);
                1:       configure(16'd0, 16'd0, 16'd0);
                2:       configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
                5:       configure(16'($urandom), 16'($urandom), 16'($urandom));
                default: configure(16'($urandom_range(0, 40)), 16'($urandom_range(0, 600)),
                                   16'($urandom_range(0, 120)));
            endcase
            if (phase == 4) begin
                write_cfg(CFG_UNUSED_IDX, 16'($urandom));
                hold_toggle = ~hold_toggle;
            end
            if (phase == 6)
                cursor_ms = 32'hFFFF_F000;
            run_gestures(PHASE_ITEMS);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
